### rtl/ptpslm_pkg.sv
// shared types, constants and log table of the peak-to-peak sound level meter
// no dependencies; imported by the interfaces, the level unit and the top level
package ptpslm_pkg;

  // sample code width taken from the low bits of the sample field
  localparam int SAMPLE_BITS = 16;

  // fixed field widths of the channels and registers
  localparam int OP_W     = 2;
  localparam int SMP_W    = 16;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int DB_W     = 16;
  localparam int P2P_W    = 16;

  // log datapath widths
  localparam int LOG_W  = $clog2(SAMPLE_BITS);
  localparam int X_W    = LOG_W + 18;
  localparam int SCL_W  = 16;
  localparam int PROD_W = X_W + SCL_W;
  localparam int LV_W   = PROD_W - 24;
  localparam int SUM_W  = LV_W + 4;

  // extreme sample codes
  localparam logic signed [SAMPLE_BITS-1:0] CODE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] CODE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // 16*20*log10(2) in Q8, log2 offset of 12 fraction bits plus log2(1.414) in Q16
  localparam logic signed [SCL_W-1:0]  LOG_SCALE  = SCL_W'(24660);
  localparam logic signed [X_W-1:0]    LOG_BIAS   = X_W'(12 * 65536 + 32782);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << 23);
  localparam logic signed [SUM_W-1:0]  DB_94      = SUM_W'(1504);

  // saturation bounds of the level
  localparam logic signed [SUM_W-1:0] LVL_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] LVL_MIN = -SUM_W'(32768);

  // register reset values
  localparam logic signed [CFG_W-1:0] MIC_SENS_RST = -CFG_W'(672);

  // log2 of 1 + f/16 in Q16
  localparam logic [15:0] LOG2_FRAC [16] = '{
    16'd0,     16'd5732,  16'd11136, 16'd16248,
    16'd21098, 16'd25711, 16'd30109, 16'd34312,
    16'd38336, 16'd42196, 16'd45904, 16'd49472,
    16'd52910, 16'd56228, 16'd59434, 16'd62534
  };

  typedef enum logic [OP_W-1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_FINISH = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIC_SENS  = 2'd0,
    CFG_EXTRA_OFS = 2'd1,
    CFG_AMP_GAIN  = 2'd2
  } cfg_idx_e;

  // finish request handed to the level unit
  typedef struct packed {
    logic                   valid;
    logic                   spread;
    logic [SAMPLE_BITS-1:0] p2p;
  } ptp_req_t;

  // calibration registers
  typedef struct packed {
    logic signed [CFG_W-1:0] mic_sens;
    logic signed [CFG_W-1:0] extra_ofs;
    logic signed [CFG_W-1:0] amp_gain;
  } ptp_cal_t;

endpackage

### rtl/ptpslm_if.sv
// valid/ready channels of the sound level meter: sample items in, reports out
// depends on ptpslm_pkg for the field widths

interface ptpslm_in_if
  import ptpslm_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [SMP_W-1:0] sample_value;
  logic                    sample_valid;

  modport source (output valid, output operation, output sample_value,
                  output sample_valid, input ready);
  modport sink   (input valid, input operation, input sample_value,
                  input sample_valid, output ready);
endinterface

interface ptpslm_out_if
  import ptpslm_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [P2P_W-1:0]       pp_span;
  logic signed [DB_W-1:0] level_db;
  logic                   level_valid;

  modport source (output valid, output pp_span, output level_db,
                  output level_valid, input ready);
  modport sink   (input valid, input pp_span, input level_db,
                  input level_valid, output ready);
endinterface

### rtl/peak_to_peak_sound_level_meter_top.sv
// top level of the peak-to-peak sound level meter: window state, registers
// depends on ptpslm_pkg, ptpslm_in_if, ptpslm_out_if and ptpslm_level
//
// item_in carries start, sample and finish beats on a valid/ready channel.
// A start opens a window and resets min/max; a sample beat with sample_valid set, in an
// open window and unlike the previous sample, updates the running min and max in the
// cycle it is accepted; a finish closes the window and sends one report beat on
// result_out with the peak-to-peak spread, the level in 1/16 dB and a level valid flag.
// Throughput: one item per cycle while item_in.ready is high. A finish report passes
// from the spread register, loaded at the edge that accepts the finish beat, through
// the log stage and the multiply stage to the result register and then appears on
// result_out.
// Up to four reports can be in flight; item_in.ready drops only when all
// stages hold reports and result_out is stalled.
// The calibration registers are to be written through cfg_we_i/cfg_idx_i/cfg_data_i
// only while no report is in flight, a rule the block does not enforce; index 3 is ignored.
// Reset closes the window, sets min to the most positive code, max to the
// most negative code, previous sample to zero, sensitivity to -672 and
// offsets to zero, and empties the report pipeline.
module peak_to_peak_sound_level_meter_top
  import ptpslm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ptpslm_in_if.sink            item_in,
  ptpslm_out_if.source         result_out,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // calibration registers
  ptp_cal_t cal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.mic_sens  <= MIC_SENS_RST;
      cal_q.extra_ofs <= '0;
      cal_q.amp_gain  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIC_SENS:  cal_q.mic_sens  <= $signed(cfg_data_i);
        CFG_EXTRA_OFS: cal_q.extra_ofs <= $signed(cfg_data_i);
        CFG_AMP_GAIN:  cal_q.amp_gain  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // handshake with the spread register
  logic                   req_v_q;
  logic                   req_spread_q;
  logic [SAMPLE_BITS-1:0] req_p2p_q;
  ptp_req_t               lvl_req;
  logic                   lvl_ready;
  logic                   req_adv;
  logic                   accept;

  assign req_adv       = !req_v_q || lvl_ready;
  assign item_in.ready = req_adv;
  assign accept        = item_in.valid && req_adv;

  // sample code from the low bits of the sample field
  logic [31:0]                   raw;
  logic signed [SAMPLE_BITS-1:0] smp;

  assign raw = 32'(unsigned'(item_in.sample_value));
  assign smp = $signed(raw[SAMPLE_BITS-1:0]);

  // window state
  logic                          open_q;
  logic signed [SAMPLE_BITS-1:0] min_q, max_q, prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      min_q  <= CODE_MAX;
      max_q  <= CODE_MIN;
      prev_q <= '0;
    end else if (accept) begin
      case (op_e'(item_in.operation))
        OP_START: begin
          open_q <= 1'b1;
          min_q  <= CODE_MAX;
          max_q  <= CODE_MIN;
          prev_q <= '0;
        end
        OP_SAMPLE: begin
          if (open_q && item_in.sample_valid && smp != prev_q) begin
            prev_q <= smp;
            if (smp < min_q) min_q <= smp;
            if (smp > max_q) max_q <= smp;
          end
        end
        OP_FINISH: begin
          open_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // spread of the current window
  logic signed [SAMPLE_BITS:0] diff;

  assign diff = (SAMPLE_BITS + 1)'(max_q) - (SAMPLE_BITS + 1)'(min_q);

  // spread register feeding the level unit
  logic fin_beat;

  assign fin_beat = accept && (item_in.operation == OP_FINISH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_v_q <= 1'b0;
    end else if (req_adv) begin
      req_v_q <= fin_beat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_adv && fin_beat) begin
      req_spread_q <= !diff[SAMPLE_BITS] && (diff != '0);
      req_p2p_q    <= diff[SAMPLE_BITS-1:0];
    end
  end

  assign lvl_req = '{valid: req_v_q, spread: req_spread_q, p2p: req_p2p_q};

  ptpslm_level u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (lvl_req),
    .req_ready_o (lvl_ready),
    .cal_i       (cal_q),
    .result_out  (result_out)
  );

endmodule

### rtl/ptpslm_level.sv
// level unit: log2 by leading one and table, scale to 1/16 dB, calibrate
// three register stages; depends on ptpslm_pkg and ptpslm_out_if
module ptpslm_level
  import ptpslm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptp_req_t           req_i,
  output logic               req_ready_o,
  input  ptp_cal_t           cal_i,
  ptpslm_out_if.source       result_out
);

  // stage valids and advance chain
  logic x_v_q, prod_v_q, out_v_q;
  logic out_adv, prod_adv, x_adv;

  assign out_adv     = !out_v_q || result_out.ready;
  assign prod_adv    = !prod_v_q || out_adv;
  assign x_adv       = !x_v_q || prod_adv;
  assign req_ready_o = x_adv;

  // leading one and fraction bits
  logic [LOG_W-1:0]       lead;
  logic [SAMPLE_BITS-1:0] norm;
  logic [3:0]             frac;
  logic signed [X_W-1:0]  x_d;

  always_comb begin
    lead = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (req_i.p2p[i]) lead = LOG_W'(i);
    end
    norm = req_i.p2p << (LOG_W'(SAMPLE_BITS - 1) - lead);
    frac = norm[SAMPLE_BITS-2 -: 4];
    x_d  = $signed(X_W'({lead, LOG2_FRAC[frac]})) - LOG_BIAS;
  end

  // stage one: log2 of the scaled spread
  logic signed [X_W-1:0]  x_q;
  logic                   x_spread_q;
  logic [SAMPLE_BITS-1:0] x_p2p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_v_q <= 1'b0;
    end else if (x_adv) begin
      x_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (x_adv && req_i.valid) begin
      x_q        <= x_d;
      x_spread_q <= req_i.spread;
      x_p2p_q    <= req_i.p2p;
    end
  end

  // stage two: multiply by the dB scale
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_spread_q;
  logic [SAMPLE_BITS-1:0]   prod_p2p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else if (prod_adv) begin
      prod_v_q <= x_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_adv && x_v_q) begin
      prod_q        <= PROD_W'(x_q) * PROD_W'(LOG_SCALE);
      prod_spread_q <= x_spread_q;
      prod_p2p_q    <= x_p2p_q;
    end
  end

  // round, calibrate and saturate
  logic signed [PROD_W-1:0] rnd;
  logic signed [SUM_W-1:0]  lv_ext;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DB_W-1:0]   level_d;
  logic [31:0]              p2p_ext;
  logic [P2P_W-1:0]         p2p_d;

  always_comb begin
    rnd    = prod_q + ROUND_HALF;
    // upper bits taken as signed give the floor of the shift
    lv_ext = SUM_W'($signed(rnd[PROD_W-1:24]));
    sum    = lv_ext - SUM_W'(cal_i.mic_sens) + DB_94 + SUM_W'(cal_i.extra_ofs)
           - SUM_W'(cal_i.amp_gain);
    if (sum > LVL_MAX) begin
      level_d = LVL_MAX[DB_W-1:0];
    end else if (sum < LVL_MIN) begin
      level_d = LVL_MIN[DB_W-1:0];
    end else begin
      level_d = sum[DB_W-1:0];
    end
    p2p_ext = 32'(prod_p2p_q);
    p2p_d   = (p2p_ext > 32'hFFFF) ? {P2P_W{1'b1}} : p2p_ext[P2P_W-1:0];
  end

  // stage three: result register
  logic [P2P_W-1:0]       p2p_q;
  logic signed [DB_W-1:0] level_q;
  logic                   level_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= prod_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && prod_v_q) begin
      if (prod_spread_q) begin
        p2p_q      <= p2p_d;
        level_q    <= level_d;
        level_ok_q <= 1'b1;
      end else begin
        p2p_q      <= '0;
        level_q    <= LVL_MIN[DB_W-1:0];
        level_ok_q <= 1'b0;
      end
    end
  end

  assign result_out.valid       = out_v_q;
  assign result_out.pp_span     = p2p_q;
  assign result_out.level_db    = level_q;
  assign result_out.level_valid = level_ok_q;

endmodule
